FILE: rtl/core/sliding_median_spike_alert_macros.svh
// assertion macros for the sliding median spike alert block
// plain header, no dependencies; define ASSERT_OFF to drop every check
`ifndef SLIDING_MEDIAN_SPIKE_ALERT_MACROS_SVH
`define SLIDING_MEDIAN_SPIKE_ALERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SMSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define SMSA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define SMSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMSA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg)
`endif
`endif

FILE: rtl/core/smsa_pkg.sv
// shared types and constants of the sliding median spike alert block
// no dependencies
package smsa_pkg;

    localparam int CFG_W = 7;
    localparam int COUNT_W = 32;
    localparam logic [CFG_W-1:0] WIN_RESET = 7'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_INS
    } t_state;

    // one shift command for the whole sorted chain
    typedef struct packed {
        logic del;
        logic ins;
    } t_cell_ctl;

endpackage

FILE: rtl/core/smsa_chan_if.sv
// valid/ready channels of the sliding median spike alert block
// depends on smsa_pkg
interface smsa_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface smsa_result_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          judged;
    logic                          alert;
    logic [SAMPLE_BITS:0]          doubled_median;
    logic [smsa_pkg::COUNT_W-1:0]  alert_total;

    modport source (output valid, output judged, output alert, output doubled_median,
                    output alert_total, input ready);
    modport sink (input valid, input judged, input alert, input doubled_median,
                  input alert_total, output ready);
endinterface

interface smsa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [smsa_pkg::CFG_W-1:0]  window_size;

    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface

FILE: rtl/core/sliding_median_spike_alert.sv
// Sliding median spike alert, top level (uses smsa_pkg, smsa_chan_if, smsa_cell and
// the assertion macro header). Each sample enters a ring history held in a memory and a
// sorted chain of WINDOW_MAX cells; once window_size samples are held, a sample at or
// above the sum of the two middle entries (twice the middle one for an odd window)
// raises alert and bumps a saturating 32-bit count. An item goes through accept, then the
// chain insert while the window fills, and through accept, then the judge and chain delete
// step, then the insert once it is full; the insert waits for a free output register. The
// chain shifts once per cycle, so delete and insert have a state each. The next sample is taken
// as soon as the block is back idle, while a finished result may still wait in the
// output register. Writing window_size restarts the fill but keeps the alert count.
`include "sliding_median_spike_alert_macros.svh"

module sliding_median_spike_alert #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smsa_sample_if.sink     i_sample,
    smsa_result_if.source   o_result,
    smsa_cfg_if.sink        i_cfg
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = $clog2(WINDOW_MAX);

    smsa_pkg::t_state                r_state, n_state;
    logic [smsa_pkg::CFG_W-1:0]      r_win, n_win;
    logic [CNT_W-1:0]                r_fill, n_fill;
    logic [PTR_W-1:0]                r_ptr, n_ptr;
    logic [smsa_pkg::COUNT_W-1:0]    r_cnt, n_cnt;
    logic                            r_full, n_full;
    logic                            r_judged, n_judged;
    logic                            r_alert, n_alert;
    logic [SAMPLE_BITS:0]            r_dm, n_dm;
    logic                            r_o_valid, n_o_valid;
    logic [SAMPLE_BITS-1:0]          r_sample;
    logic [SAMPLE_BITS-1:0]          r_old;
    logic                            r_o_judged;
    logic                            r_o_alert;
    logic [SAMPLE_BITS:0]            r_o_dm;
    logic [smsa_pkg::COUNT_W-1:0]    r_o_total;
    logic [SAMPLE_BITS-1:0]          r_hist [WINDOW_MAX];

    logic                            w_in_acc;
    logic                            w_cfg_wr;
    logic                            w_load;
    logic                            w_hist_we;
    logic [PTR_W-1:0]                w_hist_addr;
    logic [CNT_W-1:0]                w_eff;
    logic [CNT_W-1:0]                w_live_n;
    logic [PTR_W-1:0]                w_lo_idx;
    logic [PTR_W-1:0]                w_hi_idx;
    logic [SAMPLE_BITS:0]            w_dm;
    logic                            w_alert;
    smsa_pkg::t_cell_ctl             w_ctl;

    logic [SAMPLE_BITS-1:0]          w_val      [WINDOW_MAX];
    logic                            w_lt       [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]          w_prev_val [WINDOW_MAX];
    logic                            w_prev_lt  [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]          w_next_val [WINDOW_MAX];

    assign i_sample.ready = (r_state == smsa_pkg::S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign w_in_acc       = i_sample.valid && i_sample.ready;
    assign w_cfg_wr       = i_cfg.valid && i_cfg.ready;

    assign o_result.valid          = r_o_valid;
    assign o_result.judged         = r_o_judged;
    assign o_result.alert          = r_o_alert;
    assign o_result.doubled_median = r_o_dm;
    assign o_result.alert_total    = r_o_total;

    // zero acts as one, anything past the chain length saturates
    always_comb begin
        if (r_win == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_win) > WINDOW_MAX) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(r_win);
        end
    end

    // lower and upper middle coincide for an odd window
    assign w_lo_idx = PTR_W'((w_eff - CNT_W'(1)) >> 1);
    assign w_hi_idx = PTR_W'(w_eff >> 1);
    assign w_dm     = {1'b0, w_val[w_lo_idx]} + {1'b0, w_val[w_hi_idx]};
    assign w_alert  = ({1'b0, r_sample} >= w_dm);

    // number of live sorted entries seen by the chain this cycle
    always_comb begin
        if (r_state == smsa_pkg::S_DEL) begin
            w_live_n = w_eff;
        end else if (r_full) begin
            w_live_n = w_eff - CNT_W'(1);
        end else begin
            w_live_n = r_fill;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_prev_val[gi] = r_sample;
                assign w_prev_lt[gi]  = 1'b1;
            end else begin : g_inner
                assign w_prev_val[gi] = w_val[gi-1];
                assign w_prev_lt[gi]  = w_lt[gi-1];
            end
            if (gi == WINDOW_MAX - 1) begin : g_last
                assign w_next_val[gi] = w_val[gi];
            end else begin : g_body
                assign w_next_val[gi] = w_val[gi+1];
            end

            smsa_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_live     (CNT_W'(gi) < w_live_n),
                .i_new      (r_sample),
                .i_old      (r_old),
                .i_prev_val (w_prev_val[gi]),
                .i_prev_lt  (w_prev_lt[gi]),
                .i_next_val (w_next_val[gi]),
                .o_val      (w_val[gi]),
                .o_lt       (w_lt[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_full      = r_full;
        n_judged    = r_judged;
        n_alert     = r_alert;
        n_dm        = r_dm;
        n_o_valid   = r_o_valid && !o_result.ready;
        w_load      = 1'b0;
        w_ctl       = '0;
        w_hist_we   = 1'b0;
        w_hist_addr = r_ptr;

        if (w_cfg_wr) begin
            n_win  = i_cfg.window_size;
            n_fill = '0;
            n_ptr  = '0;
        end

        unique case (r_state)
            smsa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_full = (r_fill >= w_eff);
                    if (r_fill >= w_eff) begin
                        n_state = smsa_pkg::S_DEL;
                    end else begin
                        n_judged = 1'b0;
                        n_alert  = 1'b0;
                        n_dm     = '0;
                        n_state  = smsa_pkg::S_INS;
                    end
                end
            end
            smsa_pkg::S_DEL: begin
                // judge against the window as it stood, then drop the oldest sample
                w_ctl.del = 1'b1;
                w_hist_we = 1'b1;
                n_judged  = 1'b1;
                n_alert   = w_alert;
                n_dm      = w_dm;
                if (w_alert && (r_cnt != smsa_pkg::COUNT_MAX)) begin
                    n_cnt = r_cnt + smsa_pkg::COUNT_W'(1);
                end
                if (CNT_W'(r_ptr) == w_eff - CNT_W'(1)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
                n_state = smsa_pkg::S_INS;
            end
            smsa_pkg::S_INS: begin
                // insert only once the result has somewhere to go
                if (!r_o_valid || o_result.ready) begin
                    w_ctl.ins = 1'b1;
                    w_load    = 1'b1;
                    n_o_valid = 1'b1;
                    if (!r_full) begin
                        w_hist_we   = 1'b1;
                        w_hist_addr = r_fill[PTR_W-1:0];
                        n_fill      = r_fill + CNT_W'(1);
                    end
                    n_state = smsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= smsa_pkg::S_IDLE;
            r_win     <= smsa_pkg::WIN_RESET;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_cnt     <= '0;
            r_full    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_cnt     <= n_cnt;
            r_full    <= n_full;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_judged <= n_judged;
        r_alert  <= n_alert;
        r_dm     <= n_dm;
        if (w_in_acc) begin
            r_sample <= i_sample.sample_value;
        end
        if (w_load) begin
            r_o_judged <= r_judged;
            r_o_alert  <= r_alert;
            r_o_dm     <= r_dm;
            r_o_total  <= r_cnt;
        end
    end

    // arrival history, read data registered; the entry at the oldest pointer is read every cycle
    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist[w_hist_addr] <= r_sample;
        end
        r_old <= r_hist[r_ptr];
    end

    `SMSA_ASSERT(a_fill_in_window, i_clk, i_rst_n, r_fill <= w_eff, "fill count past window")
    `SMSA_ASSERT(a_ptr_in_window, i_clk, i_rst_n, CNT_W'(r_ptr) < w_eff, "oldest pointer past window")
    `SMSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, r_state != smsa_pkg::S_IDLE, "idle right after a request")
    `SMSA_ASSERT_NEXT(a_count_only_on_judge, i_clk, i_rst_n, r_state != smsa_pkg::S_DEL, $stable(r_cnt), "alert count moved outside judge step")

endmodule

FILE: rtl/core/smsa_cell.sv
// one entry of the sorted window chain: holds a sample and shifts left or right
// depends on smsa_pkg
module smsa_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  smsa_pkg::t_cell_ctl    i_ctl,
    input  logic                   i_live,
    input  logic [SAMPLE_BITS-1:0] i_new,
    input  logic [SAMPLE_BITS-1:0] i_old,
    input  logic [SAMPLE_BITS-1:0] i_prev_val,
    input  logic                   i_prev_lt,
    input  logic [SAMPLE_BITS-1:0] i_next_val,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic                   o_lt
);

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;
    logic                   w_ge_old;

    assign o_val    = r_val;
    assign o_lt     = i_live && (r_val < i_new);
    // every live entry from the first copy of the leaving sample upward moves left
    assign w_ge_old = i_live && (r_val >= i_old);

    always_comb begin
        n_val = r_val;
        if (i_ctl.del && w_ge_old) begin
            n_val = i_next_val;
        end else if (i_ctl.ins && !o_lt) begin
            // the boundary cell takes the new sample, cells above it shift right
            n_val = i_prev_lt ? i_new : i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: bench/tb_sliding_median_spike_alert.sv
// self-checking testbench of sliding_median_spike_alert: a directed table, then random phases
// over several window sizes. Depends on smsa_pkg and the channel interfaces in smsa_chan_if.
module tb_sliding_median_spike_alert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int GAP_MAX       = 12;
    localparam int N_DIRECTED    = 23;
    localparam int N_PHASES      = 9;
    localparam int WIN_RANDOM    = -1;
    localparam int HOLD_PHASE    = 2;
    localparam int DRAIN_PHASE   = 5;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle_mode;

    typedef struct packed {
        logic                            judged;
        logic                            alert;
        logic [SAMPLE_BITS:0]            doubled_median;
        logic [smsa_pkg::COUNT_W-1:0]    alert_total;
    } t_verdict;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_TYPED,
        ROW_WINDOW
    } t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [smsa_pkg::CFG_W-1:0]      win;
        logic [SAMPLE_BITS-1:0]          value;
        t_verdict                        want;
    } t_stim_row;

    function automatic t_stim_row sample_row(input logic [SAMPLE_BITS-1:0] v);
        return '{kind: ROW_SAMPLE, win: '0, value: v, want: '0};
    endfunction

    function automatic t_stim_row typed_row(input logic [SAMPLE_BITS-1:0] v, input logic j,
                                            input logic a, input logic [SAMPLE_BITS:0] dm,
                                            input logic [smsa_pkg::COUNT_W-1:0] total);
        return '{kind: ROW_TYPED, win: '0, value: v,
                 want: '{judged: j, alert: a, doubled_median: dm, alert_total: total}};
    endfunction

    function automatic t_stim_row window_row(input logic [smsa_pkg::CFG_W-1:0] w);
        return '{kind: ROW_WINDOW, win: w, value: '0, want: '0};
    endfunction

    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // reset window of five fills first
        typed_row(16'd0, 1'b0, 1'b0, 17'd0, 32'd0),
        typed_row(16'd0, 1'b0, 1'b0, 17'd0, 32'd0),
        typed_row(16'd0, 1'b0, 1'b0, 17'd0, 32'd0),
        typed_row(16'd0, 1'b0, 1'b0, 17'd0, 32'd0),
        typed_row(16'd0, 1'b0, 1'b0, 17'd0, 32'd0),
        typed_row(16'd0, 1'b1, 1'b1, 17'd0, 32'd1),
        typed_row(16'hFFFF, 1'b1, 1'b1, 17'd0, 32'd2),
        // size zero acts as one, count survives the refill
        window_row(7'd0),
        typed_row(16'hFFFF, 1'b0, 1'b0, 17'd0, 32'd2),
        typed_row(16'd0, 1'b1, 1'b0, 17'd131070, 32'd2),
        typed_row(16'hFFFF, 1'b1, 1'b1, 17'd0, 32'd3),
        window_row(7'd2),
        sample_row(16'd100),
        sample_row(16'd300),
        sample_row(16'd400),
        sample_row(16'd399),
        window_row(7'd3),
        sample_row(16'd10),
        sample_row(16'd20),
        sample_row(16'd30),
        sample_row(16'd40),
        sample_row(16'd39),
        sample_row(16'hFFFF)
    };

    localparam int PHASE_WIN [N_PHASES] = '{64, 1, 127, 2, 0, 65, WIN_RANDOM, WIN_RANDOM, 5};
    localparam int PHASE_LEN [N_PHASES] = '{100, 30, 90, 30, 20, 80, 40, 60, 50};

    logic i_clk;
    logic i_rst_n;

    smsa_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    smsa_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();
    smsa_cfg_if                                 cfg_ch ();

    sliding_median_spike_alert #(
        .WINDOW_MAX (WINDOW_MAX),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state
    logic [smsa_pkg::CFG_W-1:0]      window_reg;
    logic [SAMPLE_BITS-1:0]          sorted_q [$];
    logic [SAMPLE_BITS-1:0]          history [WINDOW_MAX];
    int                              fill_cnt;
    int                              oldest_idx;
    logic [smsa_pkg::COUNT_W-1:0]    alert_cnt;

    t_verdict   pending_verdicts [$];
    int         mismatch_count;
    int         cycle_count;
    t_idle_mode idle_mode;
    bit         hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_gap();
        case (idle_mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return int'($urandom_range(0, GAP_MAX));
            default:   return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, GAP_MAX)) : 0;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:       return '1;
            [2:3]:   return SAMPLE_BITS'($urandom_range(0, 7));
            4:       return SAMPLE_BITS'($urandom);
            9:       return SAMPLE_BITS'($urandom_range(2000, 4000));
            default: return SAMPLE_BITS'($urandom_range(900, 1100));
        endcase
    endfunction

    function automatic void load_window(input logic [smsa_pkg::CFG_W-1:0] w);
        window_reg = w;
        fill_cnt   = 0;
        oldest_idx = 0;
        sorted_q.delete();
    endfunction

    // fills the window, or once it is full judges one sample against the doubled median and slides the window
    function automatic t_verdict judge_sample(input logic [SAMPLE_BITS-1:0] s);
        t_verdict               r;
        int                     w;
        int                     p;
        int                     pos;
        logic [SAMPLE_BITS-1:0] old;
        r = '0;
        if (window_reg == 0)
            w = 1;
        else if (window_reg > WINDOW_MAX)
            w = WINDOW_MAX;
        else
            w = int'(window_reg);
        if (fill_cnt < w) begin
            history[fill_cnt] = s;
            fill_cnt++;
        end else begin
            p = oldest_idx % w;
            if (w % 2 == 0)
                r.doubled_median = {1'b0, sorted_q[w/2-1]} + {1'b0, sorted_q[w/2]};
            else
                r.doubled_median = {sorted_q[w/2], 1'b0};
            r.judged = 1'b1;
            if ({1'b0, s} >= r.doubled_median) begin
                r.alert = 1'b1;
                if (alert_cnt != smsa_pkg::COUNT_MAX)
                    alert_cnt++;
            end
            old = history[p];
            history[p] = s;
            oldest_idx = (p + 1) % w;
            // a missing oldest value would drop the last entry
            pos = 0;
            while (pos < sorted_q.size() - 1 && sorted_q[pos] != old)
                pos++;
            sorted_q.delete(pos);
        end
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] < s)
            pos++;
        sorted_q.insert(pos, s);
        r.alert_total = alert_cnt;
        return r;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input bit typed,
                               input t_verdict want);
        int       gap;
        t_verdict got;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            sample_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        sample_ch.valid        = 1'b1;
        sample_ch.sample_value = v;
        do @(posedge i_clk); while (!sample_ch.ready);
        got = judge_sample(v);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : got);
    endtask

    task automatic drain();
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [smsa_pkg::CFG_W-1:0] w);
        drain();
        @(negedge i_clk);
        cfg_ch.valid       = 1'b1;
        cfg_ch.window_size = w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        load_window(w);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // result side: random gaps, one long hold-off on request
    initial begin
        int       gap;
        t_verdict want;
        result_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    result_ch.ready = 1'b0;
                end
            end
            gap = draw_gap();
            repeat (gap) begin
                @(negedge i_clk);
                result_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            result_ch.ready = 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: judged %0b alert %0b dm %0d total %0d",
                         $time, result_ch.judged, result_ch.alert, result_ch.doubled_median,
                         result_ch.alert_total);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (result_ch.judged !== want.judged) begin
                    $display("%0t: judged expected %0b actual %0b",
                             $time, want.judged, result_ch.judged);
                    mismatch_count++;
                end
                if (result_ch.alert !== want.alert) begin
                    $display("%0t: alert expected %0b actual %0b",
                             $time, want.alert, result_ch.alert);
                    mismatch_count++;
                end
                if (result_ch.doubled_median !== want.doubled_median) begin
                    $display("%0t: doubled_median expected %0d actual %0d",
                             $time, want.doubled_median, result_ch.doubled_median);
                    mismatch_count++;
                end
                if (result_ch.alert_total !== want.alert_total) begin
                    $display("%0t: alert_total expected %0d actual %0d",
                             $time, want.alert_total, result_ch.alert_total);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int win;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.window_size     = '0;
        mismatch_count         = 0;
        hold_req               = 1'b0;
        idle_mode              = IDLE_FULL;
        alert_cnt              = '0;
        load_window(smsa_pkg::WIN_RESET);
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            case (DIRECTED_ROWS[i].kind)
                ROW_WINDOW: begin
                    write_window(DIRECTED_ROWS[i].win);
                end
                ROW_TYPED: begin
                    send_sample(DIRECTED_ROWS[i].value, 1'b1, DIRECTED_ROWS[i].want);
                end
                default: begin
                    send_sample(DIRECTED_ROWS[i].value, 1'b0, '0);
                end
            endcase
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            win = (PHASE_WIN[ph] == WIN_RANDOM) ? int'($urandom_range(3, 70)) : PHASE_WIN[ph];
            write_window(smsa_pkg::CFG_W'(win));
            idle_mode = t_idle_mode'(ph % 3);
            // output held off while requests keep coming, so the input backs up
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN[ph]; k++) begin
                if (ph == DRAIN_PHASE && k == PHASE_LEN[ph] / 2)
                    drain();
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sliding_median_spike_alert.f
+incdir+rtl/core
rtl/core/smsa_pkg.sv
rtl/core/smsa_chan_if.sv
rtl/core/smsa_cell.sv
rtl/core/sliding_median_spike_alert.sv
bench/tb_sliding_median_spike_alert.sv
